// File: hdl/musc_pkg.sv
// ----------------------------------------------------------------------------
// Motor usage statistics package
// Shared types, codes and sizes for the usage statistics counter.
// ----------------------------------------------------------------------------
package musc_pkg;

    localparam int HISTORY_DEPTH = 3;
    localparam int COUNT_BITS    = 32;
    localparam int HIST_BASE     = 44;
    localparam int READ_LAST     = HIST_BASE + 5 * HISTORY_DEPTH;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_ERROR = 3'd1,
        OP_NEWRUN = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        REQ_NONE   = 2'd0,
        REQ_STOP   = 2'd1,
        REQ_PERIOD = 2'd2,
        REQ_ERROR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_ENABLE = 2'd0,
        CFG_START  = 2'd1,
        CFG_PERIOD = 2'd2,
        CFG_FLOOR  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        second_edge;
        logic [15:0] engine_speed;
        logic [2:0]  flight_mode;
        logic        run_command;
        logic        stop_command;
        logic        open_circuit;
        logic        over_current;
        logic [31:0] error_code;
        logic [5:0]  counter_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  write_request;
        logic        engine_started;
        logic        motor_running;
        logic [31:0] read_value;
    } t_out_word;

    typedef struct packed {
        logic        stats_enable;
        logic [15:0] start_speed;
        logic [15:0] write_period;
        logic [31:0] watchdog_floor;
    } t_cfg;

endpackage

// File: hdl/musc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the four configuration registers written through the config port.
// ----------------------------------------------------------------------------
module musc_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_cfg_ready,
    output musc_pkg::t_cfg       o_cfg
);
    musc_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stats_enable   <= 1'b1;
            r_cfg.start_speed    <= 16'd500;
            r_cfg.write_period   <= 16'd60;
            r_cfg.watchdog_floor <= 32'd200000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                musc_pkg::CFG_ENABLE: r_cfg.stats_enable   <= i_cfg_data[0];
                musc_pkg::CFG_START:  r_cfg.start_speed    <= i_cfg_data[15:0];
                musc_pkg::CFG_PERIOD: r_cfg.write_period   <= i_cfg_data[15:0];
                musc_pkg::CFG_FLOOR:  r_cfg.watchdog_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end
endmodule

// File: hdl/musc_core.sv
// ----------------------------------------------------------------------------
// Statistics core
// Holds all counters and applies one registered word per cycle.
// ----------------------------------------------------------------------------
module musc_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  musc_pkg::t_in_word    i_word,
    input  musc_pkg::t_cfg        i_cfg,
    output musc_pkg::t_out_word   o_word
);
    localparam int HD = musc_pkg::HISTORY_DEPTH;
    localparam int CB = musc_pkg::COUNT_BITS;

    logic          r_started, n_started;
    logic [3:0]    r_pre [8];
    logic [3:0]    n_pre [8];
    logic [CB-1:0] r_est [7];
    logic [CB-1:0] n_est [7];
    logic [CB-1:0] r_esr [7];
    logic [CB-1:0] n_esr [7];
    logic [CB-1:0] r_mst [8];
    logic [CB-1:0] n_mst [8];
    logic [CB-1:0] r_msr [7];
    logic [CB-1:0] n_msr [7];
    logic [CB-1:0] r_tc [3];
    logic [CB-1:0] n_tc [3];
    logic [15:0]   r_period, n_period;
    logic [CB-1:0] r_fc [12];
    logic [CB-1:0] n_fc [12];
    logic [3:0]    r_oc_tenth, n_oc_tenth;
    logic [3:0]    r_ov_tenth, n_ov_tenth;
    logic [1:0]    r_act, n_act;
    logic [31:0]   r_hcode [HD];
    logic [31:0]   n_hcode [HD];
    logic [CB-1:0] r_hcnt [HD];
    logic [CB-1:0] n_hcnt [HD];
    logic [CB-1:0] r_hrun [HD];
    logic [CB-1:0] n_hrun [HD];
    logic [CB-1:0] r_hsec [HD];
    logic [CB-1:0] n_hsec [HD];
    logic [CB-1:0] r_heng [HD];
    logic [CB-1:0] n_heng [HD];
    musc_pkg::t_out_word n_out;

    logic [2:0]  w_mode;
    logic [2:0]  w_slot;
    logic        w_run;
    logic [3:0]  w_p;
    logic [5:0]  w_rel;
    logic [2:0]  w_fld;

    always_comb begin
        n_started = r_started;
        n_pre = r_pre; n_est = r_est; n_esr = r_esr; n_mst = r_mst;
        n_msr = r_msr; n_tc = r_tc; n_period = r_period; n_fc = r_fc;
        n_oc_tenth = r_oc_tenth; n_ov_tenth = r_ov_tenth;
        n_act = r_act; n_hcode = r_hcode; n_hcnt = r_hcnt; n_hrun = r_hrun;
        n_hsec = r_hsec; n_heng = r_heng;
        n_out = '0;
        w_mode = (i_word.flight_mode > 3'd5) ? 3'd5 : i_word.flight_mode;
        w_slot = w_mode + 3'd1;
        w_run = i_word.run_command & ~i_word.stop_command;
        w_p = '0;
        w_rel = i_word.counter_index - 6'(musc_pkg::HIST_BASE);
        w_fld = '0;
        if (i_valid) begin
            case (i_word.opcode)
                musc_pkg::OP_TICK: begin
                    if (i_cfg.stats_enable) begin
                        if (!r_started) begin
                            if (i_word.engine_speed >= i_cfg.start_speed)
                                n_started = 1'b1;
                        end else if (i_word.engine_speed == 16'd0) begin
                            n_started = 1'b0;
                            n_out.write_request = musc_pkg::REQ_STOP;
                        end
                        // open circuit episode only tracked while started
                        if (n_started) begin
                            if (i_word.open_circuit) begin
                                n_fc[4] = r_fc[4] + 1'b1;
                                // count modulo ten; a wrap of the count lands on zero
                                n_oc_tenth = (r_fc[4] == '1 || r_oc_tenth == 4'd9) ?
                                             4'd0 : r_oc_tenth + 4'd1;
                                if (n_oc_tenth == 4'd0) n_fc[6] = r_fc[6] + 1'b1;
                                if (!r_act[0]) begin
                                    n_act[0] = 1'b1;
                                    n_fc[5] = r_fc[5] + 1'b1;
                                    n_fc[7] = r_fc[7] + 1'b1;
                                end
                            end else begin
                                n_act[0] = 1'b0;
                            end
                        end
                        if (i_word.over_current) begin
                            n_fc[8] = r_fc[8] + 1'b1;
                            n_ov_tenth = (r_fc[8] == '1 || r_ov_tenth == 4'd9) ?
                                         4'd0 : r_ov_tenth + 4'd1;
                            if (n_ov_tenth == 4'd0) n_fc[10] = r_fc[10] + 1'b1;
                            if (!r_act[1]) begin
                                n_act[1] = 1'b1;
                                n_fc[9]  = r_fc[9] + 1'b1;
                                n_fc[11] = r_fc[11] + 1'b1;
                            end
                        end else begin
                            n_act[1] = 1'b0;
                        end
                        if (i_word.second_edge) begin
                            n_tc[0] = r_tc[0] + 1'b1;
                            n_tc[1] = r_tc[1] + 1'b1;
                            if (n_started) begin
                                n_est[0] = r_est[0] + 1'b1;
                                n_esr[0] = r_esr[0] + 1'b1;
                                n_est[w_slot] = r_est[w_slot] + 1'b1;
                                n_esr[w_slot] = r_esr[w_slot] + 1'b1;
                            end
                            n_period = r_period + 16'd1;
                            if (n_period >= i_cfg.write_period)
                                n_out.write_request = musc_pkg::REQ_PERIOD;
                        end
                        n_out.motor_running = w_run;
                        if (w_run) begin
                            w_p = r_pre[7] + 4'd1;
                            if (w_p >= 4'd10) begin
                                n_pre[7] = '0; n_mst[7] = r_mst[7] + 1'b1;
                            end else n_pre[7] = w_p;
                            w_p = r_pre[0] + 4'd1;
                            if (w_p >= 4'd10) begin
                                n_pre[0] = '0;
                                n_mst[0] = r_mst[0] + 1'b1;
                                n_msr[0] = r_msr[0] + 1'b1;
                            end else n_pre[0] = w_p;
                            w_p = r_pre[w_slot] + 4'd1;
                            if (w_p >= 4'd10) begin
                                n_pre[w_slot] = '0;
                                n_mst[w_slot] = r_mst[w_slot] + 1'b1;
                                n_msr[w_slot] = r_msr[w_slot] + 1'b1;
                            end else n_pre[w_slot] = w_p;
                        end
                        if (n_out.write_request != musc_pkg::REQ_NONE) n_period = '0;
                    end
                end
                musc_pkg::OP_ERROR: begin
                    n_out.write_request = musc_pkg::REQ_ERROR;
                    if (i_word.error_code >= i_cfg.watchdog_floor) begin
                        n_fc[0] = r_fc[0] + 1'b1; n_fc[2] = r_fc[2] + 1'b1;
                    end else begin
                        n_fc[1] = r_fc[1] + 1'b1; n_fc[3] = r_fc[3] + 1'b1;
                    end
                    // repeat of newest entry: bump its count in place
                    if (r_hcode[0] == i_word.error_code) begin
                        n_hcnt[0] = r_hcnt[0] + 1'b1;
                    end else begin
                        for (int k = 1; k < HD; k++) begin
                            n_hcode[k] = r_hcode[k-1]; n_hcnt[k] = r_hcnt[k-1];
                            n_hrun[k]  = r_hrun[k-1];  n_hsec[k] = r_hsec[k-1];
                            n_heng[k]  = r_heng[k-1];
                        end
                        n_hcnt[0] = CB'(1);
                    end
                    n_hcode[0] = i_word.error_code;
                    n_hrun[0]  = r_tc[2];
                    n_hsec[0]  = r_tc[1];
                    n_heng[0]  = r_esr[0];
                end
                musc_pkg::OP_NEWRUN: begin
                    n_tc[2] = r_tc[2] + 1'b1;
                    n_tc[1] = '0;
                    for (int k = 0; k < 7; k++) begin
                        n_esr[k] = '0; n_msr[k] = '0;
                    end
                    n_fc[2] = '0; n_fc[3] = '0; n_fc[4] = '0;
                    n_fc[5] = '0; n_fc[8] = '0; n_fc[9] = '0;
                    n_oc_tenth = '0; n_ov_tenth = '0;
                end
                musc_pkg::OP_CLEAR: begin
                    for (int k = 0; k < 7; k++) begin
                        n_est[k] = '0; n_esr[k] = '0; n_msr[k] = '0;
                    end
                    for (int k = 0; k < 8; k++) n_mst[k] = '0;
                    for (int k = 0; k < 12; k++) n_fc[k] = '0;
                    for (int k = 0; k < HD; k++) begin
                        n_hcode[k] = '0; n_hcnt[k] = '0; n_hrun[k] = '0;
                        n_hsec[k] = '0; n_heng[k] = '0;
                    end
                    n_oc_tenth = '0; n_ov_tenth = '0;
                    n_tc[0] = '0; n_tc[1] = '0; n_tc[2] = CB'(1);
                    n_period = '0;
                end
                musc_pkg::OP_READ: begin
                    if (i_word.counter_index < 6'd7)
                        n_out.read_value = 32'(r_est[i_word.counter_index[2:0]]);
                    else if (i_word.counter_index < 6'd14)
                        n_out.read_value = 32'(r_esr[3'(i_word.counter_index - 6'd7)]);
                    else if (i_word.counter_index < 6'd22)
                        n_out.read_value = 32'(r_mst[3'(i_word.counter_index - 6'd14)]);
                    else if (i_word.counter_index < 6'd29)
                        n_out.read_value = 32'(r_msr[3'(i_word.counter_index - 6'd22)]);
                    else if (i_word.counter_index < 6'd32)
                        n_out.read_value = 32'(r_tc[2'(i_word.counter_index - 6'd29)]);
                    else if (i_word.counter_index < 6'(musc_pkg::HIST_BASE))
                        n_out.read_value = 32'(r_fc[4'(i_word.counter_index - 6'd32)]);
                    else if (7'(i_word.counter_index) < 7'(musc_pkg::READ_LAST)) begin
                        // five fields per history entry, picked by range compare
                        for (int k = 0; k < HD; k++) begin
                            if (w_rel >= 6'(5 * k) && w_rel < 6'(5 * k + 5)) begin
                                w_fld = 3'(w_rel - 6'(5 * k));
                                case (w_fld)
                                    3'd0: n_out.read_value = r_hcode[k];
                                    3'd1: n_out.read_value = 32'(r_hcnt[k]);
                                    3'd2: n_out.read_value = 32'(r_hrun[k]);
                                    3'd3: n_out.read_value = 32'(r_hsec[k]);
                                    default: n_out.read_value = 32'(r_heng[k]);
                                endcase
                            end
                        end
                    end
                end
                default: ;
            endcase
            n_out.engine_started = n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_act      <= '0;
            r_period   <= '0;
            r_oc_tenth <= '0;
            r_ov_tenth <= '0;
            for (int k = 0; k < 8; k++) begin
                r_pre[k] <= '0; r_mst[k] <= '0;
            end
            for (int k = 0; k < 7; k++) begin
                r_est[k] <= '0; r_esr[k] <= '0; r_msr[k] <= '0;
            end
            for (int k = 0; k < 12; k++) r_fc[k] <= '0;
            for (int k = 0; k < HD; k++) begin
                r_hcode[k] <= '0; r_hcnt[k] <= '0; r_hrun[k] <= '0;
                r_hsec[k] <= '0; r_heng[k] <= '0;
            end
            r_tc[0] <= '0; r_tc[1] <= '0; r_tc[2] <= CB'(1);
        end else begin
            r_started <= n_started; r_act <= n_act; r_period <= n_period;
            r_oc_tenth <= n_oc_tenth; r_ov_tenth <= n_ov_tenth;
            r_pre <= n_pre; r_mst <= n_mst; r_est <= n_est; r_esr <= n_esr;
            r_msr <= n_msr; r_fc <= n_fc; r_tc <= n_tc;
            r_hcode <= n_hcode; r_hcnt <= n_hcnt; r_hrun <= n_hrun;
            r_hsec <= n_hsec; r_heng <= n_heng;
        end
    end

    assign o_word = n_out;
endmodule

// File: hdl/motor_usage_statistics_counter.sv
// ----------------------------------------------------------------------------
// Motor usage statistics counter
// Usage counters of a propeller motor controller, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in      | input     | i_in_valid / o_in_stall
//  out     | output    | o_out_valid / i_out_stall
//  cfg     | input     | i_cfg_valid / o_cfg_ready
//
// One word per cycle while the output is not stalled: the input register feeds
// the counter update, whose result lands in the output register.
// Reset restores the register defaults and clears all counters (run number 1).
// Input stalls only while the output register is full and stalled downstream.
module motor_usage_statistics_counter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  musc_pkg::t_in_word    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output musc_pkg::t_out_word   o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    musc_pkg::t_cfg      w_cfg;
    musc_pkg::t_in_word  r_in;
    logic                r_in_vld;
    musc_pkg::t_out_word w_res;
    musc_pkg::t_out_word r_out;
    logic                r_out_vld;
    logic                w_adv;

    musc_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .o_cfg_ready, .o_cfg(w_cfg)
    );

    // advance the pipe when the output slot is free or draining
    assign w_adv      = !r_out_vld || !i_out_stall;
    assign o_in_stall = !w_adv;

    musc_core u_core (
        .i_clk, .i_rst_n, .i_valid(r_in_vld && w_adv), .i_word(r_in),
        .i_cfg(w_cfg), .o_word(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_in_vld  <= i_in_valid;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in <= i_in_data;
            if (r_in_vld) r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !o_in_stall |=> o_out_valid)
        else $error("pending word did not reach output");
endmodule

// File: test/musc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Usage statistics checker
// Watches the word, result and register channels, runs a cycle-free copy of
// the usage counters and compares every result word in order.
// ----------------------------------------------------------------------------
module musc_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  musc_pkg::t_in_word  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  musc_pkg::t_out_word i_out_data,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);

    logic        en;
    logic [15:0] start_rpm;
    logic [15:0] period_secs;
    logic [31:0] wd_floor;

    logic        started;
    logic [3:0]  presc [8];
    logic [31:0] eng_tot [7];
    logic [31:0] eng_run [7];
    logic [31:0] mot_tot [8];
    logic [31:0] mot_run [7];
    logic [31:0] tcnt [3];
    logic [15:0] pcnt;
    logic [31:0] fcnt [12];
    logic        factive [2];
    logic [63:0] hist [3*musc_pkg::HISTORY_DEPTH];

    musc_pkg::t_out_word expected_words[$];

    assign o_pending = expected_words.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    function automatic bit prescale(input int s);
        presc[s] = presc[s] + 4'd1;
        if (presc[s] >= 4'd10) begin
            presc[s] = 0;
            return 1;
        end
        return 0;
    endfunction

    task automatic track_episode(input logic present, input int which, input int base);
        if (present) begin
            fcnt[base]++;
            if (fcnt[base] % 10 == 0) fcnt[base+2]++;
            if (!factive[which]) begin
                factive[which] = 1;
                fcnt[base+1]++;
                fcnt[base+3]++;
            end
        end else begin
            factive[which] = 0;
        end
    endtask

    task automatic wipe_counters();
        for (int i = 0; i < 7; i++) begin
            eng_tot[i] = 0; eng_run[i] = 0; mot_run[i] = 0;
        end
        for (int i = 0; i < 8; i++) mot_tot[i] = 0;
        for (int i = 0; i < 12; i++) fcnt[i] = 0;
        for (int i = 0; i < 3*musc_pkg::HISTORY_DEPTH; i++) hist[i] = 0;
        tcnt[0] = 0; tcnt[1] = 0; tcnt[2] = 1;
        pcnt = 0;
    endtask

    function automatic logic [31:0] counter_at(input int idx);
        int e;
        int f;
        if (idx < 7) return eng_tot[idx];
        if (idx < 14) return eng_run[idx-7];
        if (idx < 22) return mot_tot[idx-14];
        if (idx < 29) return mot_run[idx-22];
        if (idx < 32) return tcnt[idx-29];
        if (idx < musc_pkg::HIST_BASE) return fcnt[idx-32];
        e = (idx - musc_pkg::HIST_BASE) / 5;
        f = (idx - musc_pkg::HIST_BASE) % 5;
        if (e >= musc_pkg::HISTORY_DEPTH) return 0;
        case (f)
            0: return hist[3*e][63:32];
            1: return hist[3*e][31:0];
            2: return hist[3*e+1][63:32];
            3: return hist[3*e+1][31:0];
            default: return hist[3*e+2][31:0];
        endcase
    endfunction

    task automatic predict_word(input musc_pkg::t_in_word w);
        musc_pkg::t_out_word r;
        int        slot;
        logic [31:0] cnt;
        r = '0;
        slot = (w.flight_mode > 3'd5 ? 5 : int'(w.flight_mode)) + 1;
        case (w.opcode)
            musc_pkg::OP_TICK: if (en) begin
                if (!started) begin
                    if (w.engine_speed >= start_rpm) started = 1;
                end else if (w.engine_speed == 0) begin
                    started = 0;
                    r.write_request = musc_pkg::REQ_STOP;
                end
                if (started) track_episode(w.open_circuit, 0, 4);
                track_episode(w.over_current, 1, 8);
                if (w.second_edge) begin
                    tcnt[0]++; tcnt[1]++;
                    if (started) begin
                        eng_tot[0]++; eng_run[0]++;
                        eng_tot[slot]++; eng_run[slot]++;
                    end
                    pcnt++;
                    if (pcnt >= period_secs) r.write_request = musc_pkg::REQ_PERIOD;
                end
                r.motor_running = w.run_command && !w.stop_command;
                if (r.motor_running) begin
                    if (prescale(7)) mot_tot[7]++;
                    if (prescale(0)) begin
                        mot_tot[0]++; mot_run[0]++;
                    end
                    if (prescale(slot)) begin
                        mot_tot[slot]++; mot_run[slot]++;
                    end
                end
                if (r.write_request != musc_pkg::REQ_NONE) pcnt = 0;
            end
            musc_pkg::OP_ERROR: begin
                if (w.error_code >= wd_floor) begin
                    fcnt[0]++; fcnt[2]++;
                end else begin
                    fcnt[1]++; fcnt[3]++;
                end
                cnt = 1;
                if (hist[0][63:32] == w.error_code) begin
                    cnt = hist[0][31:0] + 1;
                end else begin
                    for (int i = 3*musc_pkg::HISTORY_DEPTH-1; i >= 3; i--)
                        hist[i] = hist[i-3];
                end
                hist[0] = {w.error_code, cnt};
                hist[1] = {tcnt[2], tcnt[1]};
                hist[2] = {32'd0, eng_run[0]};
                r.write_request = musc_pkg::REQ_ERROR;
            end
            musc_pkg::OP_NEWRUN: begin
                tcnt[2]++;
                tcnt[1] = 0;
                for (int i = 0; i < 7; i++) begin
                    eng_run[i] = 0; mot_run[i] = 0;
                end
                fcnt[2] = 0; fcnt[3] = 0; fcnt[4] = 0;
                fcnt[5] = 0; fcnt[8] = 0; fcnt[9] = 0;
            end
            musc_pkg::OP_CLEAR: wipe_counters();
            musc_pkg::OP_READ: r.read_value = counter_at(int'(w.counter_index));
            default: ;
        endcase
        r.engine_started = started;
        expected_words.push_back(r);
    endtask

    always @(posedge i_clk) begin
        musc_pkg::t_out_word want;
        if (!i_rst_n) begin
            en = 1; start_rpm = 500; period_secs = 60; wd_floor = 200000;
            started = 0;
            factive[0] = 0; factive[1] = 0;
            for (int i = 0; i < 8; i++) presc[i] = 0;
            wipe_counters();
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (musc_pkg::t_cfg_idx'(i_cfg_index))
                    musc_pkg::CFG_ENABLE: en = i_cfg_data[0];
                    musc_pkg::CFG_START:  start_rpm = i_cfg_data[15:0];
                    musc_pkg::CFG_PERIOD: period_secs = i_cfg_data[15:0];
                    musc_pkg::CFG_FLOOR:  wd_floor = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report("unexpected word", i_out_data.read_value, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_data.write_request !== want.write_request)
                        report("write_request", i_out_data.write_request, want.write_request);
                    if (i_out_data.engine_started !== want.engine_started)
                        report("engine_started", i_out_data.engine_started,
                               want.engine_started);
                    if (i_out_data.motor_running !== want.motor_running)
                        report("motor_running", i_out_data.motor_running, want.motor_running);
                    if (i_out_data.read_value !== want.read_value)
                        report("read_value", i_out_data.read_value, want.read_value);
                end
            end
            if (i_in_valid && !i_in_stall) predict_word(i_in_data);
        end
    end

    initial o_errors = 0;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Usage statistics counter testbench
// Drives directed and random words with random idling on both channels,
// sweeps the registers between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDLE_LIMIT = 5000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    musc_pkg::t_in_word  in_data;
    logic                out_valid;
    logic                out_stall;
    musc_pkg::t_out_word out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [31:0]         cfg_data;
    int                  errors;
    int                  pending;
    bit                  quiet;
    bit                  hold_off;
    int                  idle_cycles;
    logic [15:0]         cur_start;

    motor_usage_statistics_counter uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    musc_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // downstream stall bursts, or a long hold-off on request
    always @(posedge clk) begin
        if (!rst_n || quiet) begin
            out_stall <= 0;
        end else if (hold_off) begin
            out_stall <= 1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_stall <= 1;
            repeat ($urandom_range(1, 13)) @(posedge clk);
            out_stall <= 0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("motor_usage_statistics_counter verification failed");
            $finish;
        end
    end

    task automatic write_reg(input musc_pkg::t_cfg_idx idx, input logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // leave valid high on return so words can follow back to back
    task automatic send_word(input musc_pkg::t_in_word w);
        if (!quiet && $urandom_range(0, 6) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic musc_pkg::t_in_word rand_word();
        musc_pkg::t_in_word w;
        logic [95:0] raw;
        int pick;
        raw = {$urandom, $urandom, $urandom};
        w = raw[$bits(musc_pkg::t_in_word)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 70) w.opcode = musc_pkg::OP_TICK;
        else if (pick < 80) w.opcode = musc_pkg::OP_ERROR;
        else if (pick < 84) w.opcode = musc_pkg::OP_NEWRUN;
        else if (pick < 86) w.opcode = musc_pkg::OP_CLEAR;
        else if (pick < 97) w.opcode = musc_pkg::OP_READ;
        else w.opcode = 3'($urandom_range(5, 7));
        // a quarter of words at the start threshold, a quarter at zero speed
        case ($urandom_range(0, 3))
            0: w.engine_speed = 16'd0;
            1: w.engine_speed = cur_start;
            default: ;
        endcase
        w.open_circuit = $urandom_range(0, 3) != 0;
        w.over_current = $urandom_range(0, 2) != 0;
        if ($urandom_range(0, 1)) w.error_code = $urandom_range(199990, 200010);
        if ($urandom_range(0, 2) == 0) w.error_code = 32'd7;
        if ($urandom_range(0, 1))
            w.counter_index = 6'($urandom_range(0, musc_pkg::READ_LAST));
        return w;
    endfunction

    task automatic send_tick(input logic sec, input logic [15:0] rpm, input logic [2:0] mode,
                             input logic run, input logic stp, input logic oc, input logic ov);
        musc_pkg::t_in_word w;
        w = '0;
        w.opcode = musc_pkg::OP_TICK;
        w.second_edge = sec; w.engine_speed = rpm; w.flight_mode = mode;
        w.run_command = run; w.stop_command = stp;
        w.open_circuit = oc; w.over_current = ov;
        send_word(w);
    endtask

    task automatic send_op(input musc_pkg::t_opcode op, input logic [31:0] code,
                           input logic [5:0] idx);
        musc_pkg::t_in_word w;
        w = '0;
        w.opcode = op; w.error_code = code; w.counter_index = idx;
        send_word(w);
    endtask

    initial begin
        musc_pkg::t_in_word w;
        rst_n = 0; in_valid = 0; in_data = '0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        quiet = 0; hold_off = 0; cur_start = 500;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: open circuit before start, start, faults, all modes, stop
        send_tick(1, 16'd0, 3'd0, 1, 0, 1, 1);
        send_tick(0, 16'd500, 3'd1, 1, 1, 1, 0);
        for (int m = 0; m < 8; m++) send_tick(1, 16'hFFFF, 3'(m), 1, 0, 1, 1);
        send_tick(1, 16'd0, 3'd2, 0, 0, 0, 0);
        send_op(musc_pkg::OP_ERROR, 32'd0, 6'd0);
        send_op(musc_pkg::OP_ERROR, 32'd0, 6'd0);
        send_op(musc_pkg::OP_ERROR, 32'hFFFFFFFF, 6'd0);
        send_op(musc_pkg::OP_ERROR, 32'd200000, 6'd0);
        send_op(musc_pkg::OP_ERROR, 32'd199999, 6'd0);
        send_op(musc_pkg::OP_READ, 32'd44, 6'd44);
        send_op(musc_pkg::OP_READ, 32'd45, 6'd45);
        send_op(musc_pkg::OP_READ, 32'd63, 6'd63);
        send_op(musc_pkg::OP_NEWRUN, 32'd0, 6'd0);
        send_op(musc_pkg::OP_READ, 32'd0, 6'd31);
        w = '1; w.opcode = 3'd7; send_word(w);
        send_op(musc_pkg::OP_CLEAR, 32'd0, 6'd0);
        send_op(musc_pkg::OP_READ, 32'd0, 6'd44);
        drain();

        // period zero and disabled phase
        write_reg(musc_pkg::CFG_PERIOD, 32'd0);
        write_reg(musc_pkg::CFG_START, 32'd0);
        send_tick(1, 16'd0, 3'd3, 1, 0, 0, 0);
        send_tick(1, 16'd0, 3'd3, 1, 0, 0, 0);
        drain();
        write_reg(musc_pkg::CFG_ENABLE, 32'd0);
        send_tick(1, 16'hFFFF, 3'd4, 1, 0, 1, 1);
        send_op(musc_pkg::OP_ERROR, 32'd5, 6'd0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(musc_pkg::CFG_ENABLE, ph == 1 ? 32'd0 : 32'd1);
            cur_start = ph == 2 ? 16'hFFFF : 16'($urandom_range(0, 1000));
            write_reg(musc_pkg::CFG_START, {16'd0, cur_start});
            write_reg(musc_pkg::CFG_PERIOD, ph == 3 ? 32'd65535 : 32'($urandom_range(1, 5)));
            write_reg(musc_pkg::CFG_FLOOR,
                      ph == 4 ? 32'hFFFFFFFF : (ph == 5 ? 32'd0 : 32'd200000));
            if (ph == 5) quiet = 1;
            for (int n = 0; n < 100; n++) begin
                if (ph == 2 && n == 10) begin
                    fork
                        begin
                            hold_off = 1;
                            repeat (40) @(posedge clk);
                            hold_off = 0;
                        end
                    join_none
                end
                send_word(rand_word());
            end
            drain();
        end

        if (errors == 0)
            $display("motor_usage_statistics_counter verification clean");
        else
            $display("motor_usage_statistics_counter verification failed");
        $finish;
    end

endmodule
